/* hw/rtl/mst_pkg.sv */
// package: shared constants, codes and interface types of the segment tracker
package mst_pkg;

  localparam int MAX_SEGMENTS = 8192;
  localparam int MAP_WORDS    = (MAX_SEGMENTS + 31) / 32;
  localparam int WORD_AW      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 16;

  localparam logic [6:0] PCT_FULL = 7'd100;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_DUP    = 2'd1,
    ST_BAD    = 2'd2,
    ST_HEADER = 2'd3
  } status_t;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_BODY   = 1'b1
  } opcode_t;

  typedef enum logic {
    CFG_PAD_MODE   = 1'b0,
    CFG_IMAGE_TYPE = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_HDR, S_RD, S_MOD, S_DIV, S_CHECK, S_SCAN, S_EMIT
  } state_t;

  // request to the percentage unit
  typedef struct packed {
    logic        start;
    logic [26:0] bytes;
    logic [27:0] total;
  } div_req_t;

  // answer of the percentage unit
  typedef struct packed {
    logic       done;
    logic [6:0] percent;
  } div_rsp_t;

endpackage

/* hw/rtl/mst_map_ram.sv */
// single-port memory holding the received-segment bitmap
module mst_map_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      rd,
  input  logic [mst_pkg::WORD_AW-1:0] addr,
  input  logic [31:0]               wdata,
  output logic [31:0]               rdata
);
  import mst_pkg::*;

  logic [31:0] mem [MAP_WORDS];
  logic [31:0] rdata_r;

  // write or registered read, one access per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/mst_pct_div.sv */
// load percentage unit: bytes*100/total, one quotient bit per cycle, saturated
module mst_pct_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mst_pkg::div_req_t req,
  output mst_pkg::div_rsp_t rsp
);
  import mst_pkg::*;

  logic        busy_r;
  logic        pre_r;
  logic [33:0] rem_r;
  logic [33:0] dsh_r;
  logic [27:0] den_r;
  logic [6:0]  q_r;
  logic [2:0]  cnt_r;
  logic        done_r;
  logic [6:0]  pct_r;
  logic        fits;
  logic [6:0]  q_new;

  // one restoring step
  always_comb begin
    fits  = rem_r >= dsh_r;
    q_new = fits ? (q_r | (7'd1 << cnt_r)) : q_r;
  end

  // sequencing of the compare and the seven steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        pre_r  <= 1'b1;
        rem_r  <= 34'(req.bytes) * 34'(PCT_FULL);
        den_r  <= req.total;
        dsh_r  <= {req.total, 6'b0};
        q_r    <= '0;
        cnt_r  <= 3'd6;
      end else if (busy_r && pre_r) begin
        pre_r <= 1'b0;
        // quotient of 128 or more saturates at once
        if ({1'b0, rem_r} >= {den_r, 7'b0}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          pct_r  <= PCT_FULL;
        end
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= rem_r - dsh_r;
        end
        q_r   <= q_new;
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          pct_r  <= (q_new > PCT_FULL) ? PCT_FULL : q_new;
        end
      end
    end
  end

  assign rsp.done    = done_r;
  assign rsp.percent = pct_r;

endmodule

/* hw/rtl/mot_segment_tracker.sv */
// top level: segment reassembly tracker with bitmap memory and control sequencer
//
// Input beats carry either a header core (tuser 0) or a body segment (tuser 1);
// each input beat yields exactly one output beat with status in out_tuser and
// progress and completion flags in out_tdata. Registers are written through
// cfg_we/cfg_addr/cfg_wdata; the user writes them only while the block is idle,
// the block itself does not enforce this. A load percentage, when computed,
// comes from a bit-serial divider. Once the header, the total and enough
// segments are present, the bitmap is checked for completion one 32-bit word
// per cycle, up to 256 words. A new transport id adds a bitmap clearing
// sweep, one memory word per cycle.
// The bitmap lives in a single-port memory; the controller sequences its
// clearing writes, segment read and write-back, and scan reads, beat by beat.
// After reset the same sweep clears the bitmap; in_tready stays low
// until it ends, configuration writes are taken throughout.
// A finished result waits in the output register while the next input beat is
// taken; if the receiver stalls, the block holds the next result until the
// output register is free.
module mot_segment_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  // fields: transport_id[15:0], header_core[71:16], segment_number[87:72],
  // segment_size[100:88], zero fill
  input  logic [mst_pkg::IN_TDATA_W-1:0]  in_tdata,
  // fields: opcode[0]
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // fields: progress_valid[0], progress_percent[7:1], complete[8], zero fill
  output logic [mst_pkg::OUT_TDATA_W-1:0] out_tdata,
  // fields: status[1:0]
  output logic [1:0]                      out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic                            cfg_addr,
  input  logic [5:0]                      cfg_wdata
);
  import mst_pkg::*;

  state_t state_r, state_nxt, ret_r;

  logic               pad_mode_r;
  logic [5:0]         image_type_r;

  logic               op_r;
  logic [15:0]        tid_r;
  logic [55:0]        hc_r;
  logic [15:0]        seg_r;
  logic [12:0]        size_r;
  logic               last_r;

  logic [15:0]        current_id_r;
  logic               id_known_r;
  logic               header_known_r;
  logic [27:0]        body_total_r;
  logic [5:0]         kind_r;
  logic [13:0]        seg_total_r;
  logic               total_known_r;
  logic [13:0]        rcv_count_r;
  logic [26:0]        rcv_bytes_r;

  logic [WORD_AW-1:0] clr_r;
  logic [WORD_AW-1:0] scan_r;

  status_t            res_status_r;
  logic               res_pv_r;
  logic [6:0]         res_pct_r;
  logic               res_done_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic               out_pv_r;
  logic [6:0]         out_pct_r;
  logic               out_done_r;

  logic               ram_we, ram_rd;
  logic [WORD_AW-1:0] ram_addr;
  logic [31:0]        ram_wdata, ram_rdata;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               new_id, bad_seg, bit_set, pcond, ready_chk, word_ok, out_free;
  logic [15:0]        seg_word;
  logic [WORD_AW-1:0] seg_addr;
  logic [31:0]        bit_mask, chk_mask;
  logic [26:0]        bytes_upd;
  logic [13:0]        tot_m1, last_w14;
  logic [WORD_AW-1:0] last_w;

  mst_map_ram u_map (
    .clk   (clk),
    .we    (ram_we),
    .rd    (ram_rd),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  mst_pct_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // item decode and derived values
  always_comb begin
    new_id    = !id_known_r || (current_id_r != tid_r);
    bad_seg   = seg_r[15] || (seg_r >= 16'(MAX_SEGMENTS));
    seg_word  = seg_r >> 5;
    seg_addr  = seg_word[WORD_AW-1:0];
    bit_mask  = 32'd1 << seg_r[4:0];
    bit_set   = (ram_rdata & bit_mask) != 32'd0;
    bytes_upd = rcv_bytes_r + 27'(size_r);
    pcond     = pad_mode_r && (body_total_r != 28'd0) && (kind_r == image_type_r);
    ready_chk = header_known_r && total_known_r && (rcv_count_r >= seg_total_r);
    tot_m1    = seg_total_r - 14'd1;
    last_w14  = tot_m1 >> 5;
    last_w    = last_w14[WORD_AW-1:0];
    chk_mask  = (scan_r == last_w) ? (32'hFFFF_FFFF >> (5'd31 - tot_m1[4:0])) : 32'hFFFF_FFFF;
    word_ok   = (ram_rdata & chk_mask) == chk_mask;
    out_free  = !out_valid_r || out_tready;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, memory and divider control
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    ram_rd        = 1'b0;
    ram_addr      = '0;
    ram_wdata     = '0;
    div_req.start = 1'b0;
    div_req.bytes = rcv_bytes_r;
    div_req.total = body_total_r;
    case (state_r)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
        if (clr_r == WORD_AW'(MAP_WORDS - 1)) begin
          state_nxt = ret_r;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (op_r == OP_HEADER) begin
          state_nxt = new_id ? S_CLEAR : S_HDR;
        end else if (bad_seg) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = new_id ? S_CLEAR : S_RD;
        end
      end
      S_HDR: begin
        state_nxt = S_CHECK;
      end
      S_RD: begin
        ram_rd    = 1'b1;
        ram_addr  = seg_addr;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (bit_set) begin
          state_nxt = S_EMIT;
        end else begin
          ram_we    = 1'b1;
          ram_addr  = seg_addr;
          ram_wdata = ram_rdata | bit_mask;
          if (pcond) begin
            div_req.start = 1'b1;
            div_req.bytes = bytes_upd;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!ready_chk || (seg_total_r == 14'd0)) begin
          state_nxt = S_EMIT;
        end else begin
          ram_rd    = 1'b1;
          ram_addr  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!word_ok || (scan_r == last_w)) begin
          state_nxt = S_EMIT;
        end else begin
          ram_rd   = 1'b1;
          ram_addr = scan_r + WORD_AW'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_mode_r   <= 1'b0;
      image_type_r <= 6'd2;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_PAD_MODE:   pad_mode_r   <= cfg_wdata[0];
        CFG_IMAGE_TYPE: image_type_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r   <= in_tuser;
      tid_r  <= in_tdata[15:0];
      hc_r   <= in_tdata[71:16];
      seg_r  <= in_tdata[87:72];
      size_r <= in_tdata[100:88];
      last_r <= in_tlast;
    end
  end

  // object state, sweep counters and result fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ret_r          <= S_IDLE;
      clr_r          <= '0;
      current_id_r   <= '0;
      id_known_r     <= 1'b0;
      header_known_r <= 1'b0;
      body_total_r   <= '0;
      kind_r         <= '0;
      seg_total_r    <= '0;
      total_known_r  <= 1'b0;
      rcv_count_r    <= '0;
      rcv_bytes_r    <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + WORD_AW'(1);
        end
        S_DECODE: begin
          res_status_r <= ST_BAD;
          res_pv_r     <= 1'b0;
          res_pct_r    <= '0;
          res_done_r   <= 1'b0;
          ret_r        <= (op_r == OP_HEADER) ? S_HDR : S_RD;
          clr_r        <= '0;
          // new object drops everything learned so far
          if (new_id && ((op_r == OP_HEADER) || !bad_seg)) begin
            current_id_r   <= tid_r;
            id_known_r     <= 1'b1;
            header_known_r <= 1'b0;
            body_total_r   <= '0;
            kind_r         <= '0;
            seg_total_r    <= '0;
            total_known_r  <= 1'b0;
            rcv_count_r    <= '0;
            rcv_bytes_r    <= '0;
          end
        end
        S_HDR: begin
          body_total_r   <= hc_r[55:28];
          kind_r         <= hc_r[14:9];
          header_known_r <= 1'b1;
          res_status_r   <= ST_HEADER;
        end
        S_MOD: begin
          if (bit_set) begin
            res_status_r <= ST_DUP;
          end else begin
            res_status_r <= ST_STORED;
            rcv_count_r  <= rcv_count_r + 14'd1;
            rcv_bytes_r  <= bytes_upd;
            if (last_r) begin
              seg_total_r   <= seg_r[13:0] + 14'd1;
              total_known_r <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_pv_r  <= 1'b1;
            res_pct_r <= div_rsp.percent;
          end
        end
        S_CHECK: begin
          scan_r     <= '0;
          res_done_r <= ready_chk && (seg_total_r == 14'd0);
        end
        S_SCAN: begin
          scan_r     <= scan_r + WORD_AW'(1);
          res_done_r <= word_ok && (scan_r == last_w);
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_EMIT) && out_free) begin
      out_valid_r  <= 1'b1;
      out_status_r <= res_status_r;
      out_pv_r     <= res_pv_r;
      out_pct_r    <= res_pct_r;
      out_done_r   <= res_done_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_done_r, out_pct_r, out_pv_r};

endmodule

/* hw/rtl/mst_checker.sv */
// port-level checks of the segment tracker and their binding
module mst_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic [mst_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready
);
  import mst_pkg::*;

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // duplicates and bad numbers never report completion
  a_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_DUP || out_tuser == ST_BAD) |-> !out_tdata[8])
    else $error("completion on rejected segment");

  // percentage is zero unless reported
  a_pct_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[7:1] == 7'd0)
    else $error("percentage without progress flag");

  // percentage never exceeds full and header beats carry none
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:1] <= PCT_FULL) && !(out_tuser == ST_HEADER && out_tdata[0]))
    else $error("bad progress report");

endmodule

bind mot_segment_tracker mst_checker u_mst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

/* verif/tb_mot_segment_tracker.sv */
// testbench: segment reassembly tracker against a behavioral predictor
module tb_mot_segment_tracker;
  import mst_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_we;
  logic                   cfg_addr;
  logic [5:0]             cfg_wdata;

  typedef struct packed {
    status_t    status;
    logic       pvalid;
    logic [6:0] percent;
    logic       done;
  } seg_result_t;

  seg_result_t expected_q[$];
  int          fail_count;
  int          cycle_count;

  // predictor copy of registers and object state
  logic          m_pad;
  logic [5:0]    m_image;
  logic [15:0]   m_id;
  logic          m_id_known;
  logic          m_hdr_known;
  logic [27:0]   m_body_total;
  logic [5:0]    m_kind;
  logic [13:0]   m_seg_total;
  logic          m_total_known;
  logic [13:0]   m_rx_count;
  logic [26:0]   m_rx_bytes;
  logic [8191:0] m_map;

  // current tid of the random object stream
  logic [15:0]   cur_tid;

  mot_segment_tracker u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tlast(in_tlast),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void clear_object();
    m_hdr_known   = 1'b0;
    m_body_total  = '0;
    m_kind        = '0;
    m_seg_total   = '0;
    m_total_known = 1'b0;
    m_rx_count    = '0;
    m_rx_bytes    = '0;
    m_map         = '0;
  endfunction

  function automatic void track_id(logic [15:0] tid);
    if (!m_id_known || m_id != tid) begin
      clear_object();
      m_id       = tid;
      m_id_known = 1'b1;
    end
  endfunction

  function automatic logic object_done();
    if (!m_hdr_known || !m_total_known || m_rx_count < m_seg_total) return 1'b0;
    for (int i = 0; i < m_seg_total && i < MAX_SEGMENTS; i++)
      if (!m_map[i]) return 1'b0;
    return 1'b1;
  endfunction

  // predicted result of one beat
  function automatic seg_result_t predict_segment(opcode_t op, logic [15:0] tid,
      logic [55:0] hc, logic [15:0] num, logic [12:0] size, logic last);
    seg_result_t r;
    logic [63:0] p;
    r = '0;
    if (op == OP_HEADER) begin
      track_id(tid);
      m_body_total = hc[55:28];
      m_kind       = hc[14:9];
      m_hdr_known  = 1'b1;
      r.status     = ST_HEADER;
      r.done       = object_done();
    end else if (num[15] || num >= MAX_SEGMENTS) begin
      r.status = ST_BAD;
    end else begin
      track_id(tid);
      if (m_map[num[12:0]]) begin
        r.status = ST_DUP;
      end else begin
        m_map[num[12:0]] = 1'b1;
        m_rx_count = m_rx_count + 14'd1;
        m_rx_bytes = m_rx_bytes + 27'(size);
        if (last) begin
          m_seg_total   = 14'(num) + 14'd1;
          m_total_known = 1'b1;
        end
        if (m_pad && m_body_total != 0 && m_kind == m_image) begin
          p = (64'(m_rx_bytes) * 64'd100) / 64'(m_body_total);
          r.percent = (p > 100) ? PCT_FULL : 7'(p);
          r.pvalid  = 1'b1;
        end
        r.status = ST_STORED;
        r.done   = object_done();
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  // send one beat and queue its expected result
  task automatic send_beat(opcode_t op, logic [15:0] tid, logic [55:0] hc,
      logic [15:0] num, logic [12:0] size, logic last);
    int n;
    n = $urandom_range(0, 4) * ($urandom_range(0, 3) != 0);
    if (n != 0) begin
      in_tvalid <= 1'b0;
      idle_cycles(n);
    end
    in_tdata  <= {3'b000, size, num, hc, tid};
    in_tuser  <= op;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_segment(op, tid, hc, num, size, last));
    @(negedge clk);
  endtask

  task automatic send_header(logic [15:0] tid, logic [27:0] body, logic [5:0] kind);
    send_beat(OP_HEADER, tid, {body, 13'($urandom), kind, 9'($urandom)}, '0, '0, 1'b0);
  endtask

  task automatic send_body(logic [15:0] tid, logic [15:0] num, logic [12:0] size,
      logic last);
    send_beat(OP_BODY, tid, 56'({$urandom, $urandom}), num, size, last);
  endtask

  // wait for every expected result plus the longest clearing sweep
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    idle_cycles(600);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [5:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    if (idx == CFG_PAD_MODE) m_pad = value[0];
    else m_image = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    seg_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result beat");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_tuser != want.status) report_mismatch("status", out_tuser, want.status);
        if (out_tdata[0] != want.pvalid) report_mismatch("progress_valid", out_tdata[0], want.pvalid);
        if (out_tdata[7:1] != want.percent)
          report_mismatch("progress_percent", out_tdata[7:1], want.percent);
        if (out_tdata[8] != want.done) report_mismatch("complete", out_tdata[8], want.done);
        if (out_tdata[15:9] != 0) report_mismatch("tdata fill", out_tdata[15:9], 0);
      end
    end
  end

  // receiver: a random wait before each result beat
  initial begin : rx_proc
    int n;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      n = $urandom_range(0, 4);
      if (n != 0) begin
        out_tready <= 1'b0;
        idle_cycles(n);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // directed: field extremes, each status, header repeat and the no-progress cases
  task automatic test_directed();
    write_reg(CFG_PAD_MODE, 6'd1);
    write_reg(CFG_IMAGE_TYPE, 6'd2);
    send_body(16'h0000, 16'h8000, 13'h1FFF, 1'b1);
    send_body(16'hFFFF, 16'd8192, 13'd5, 1'b0);
    send_body(16'hFFFF, 16'hFFFF, 13'd5, 1'b1);
    send_body(16'h1234, 16'd0, 13'd0, 1'b0);
    send_header(16'h1234, 28'd0, 6'd2);
    send_body(16'h1234, 16'd1, 13'h1FFF, 1'b0);
    send_header(16'h1234, 28'hFFFFFFF, 6'd2);
    send_body(16'h1234, 16'd8191, 13'h1FFF, 1'b1);
    send_body(16'h1234, 16'd8191, 13'd1, 1'b1);
    send_header(16'h1234, 28'd100, 6'd2);
    send_body(16'h1234, 16'd2, 13'd4000, 1'b1);
    send_body(16'h1234, 16'd3, 13'd10, 1'b1);
    send_beat(OP_HEADER, 16'hFFFF, 56'hFF_FFFF_FFFF_FFFF, '0, '0, 1'b1);
    send_body(16'hFFFF, 16'd0, 13'd50, 1'b1);
    send_header(16'h0000, 28'd300, 6'd3);
    send_body(16'h0000, 16'd0, 13'd100, 1'b1);
    drain();
    write_reg(CFG_IMAGE_TYPE, 6'd63);
    send_header(16'h00AA, 28'd1000, 6'd63);
    send_body(16'h00AA, 16'd0, 13'd999, 1'b0);
    send_body(16'h00AA, 16'd1, 13'd1, 1'b1);
    drain();
    write_reg(CFG_PAD_MODE, 6'd0);
    write_reg(CFG_IMAGE_TYPE, 6'd0);
    send_header(16'h00AB, 28'd1000, 6'd0);
    send_body(16'h00AB, 16'd0, 13'd10, 1'b1);
    drain();
  endtask

  // random objects: mostly well formed, some noise, on a small id set
  task automatic test_random_objects(int count);
    int nseg;
    int sent;
    logic [15:0] r;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) cur_tid = 16'($urandom);
      else cur_tid = 16'($urandom_range(0, 3));
      nseg = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        send_header(cur_tid, 28'($urandom_range(1, 20000)),
                    ($urandom_range(0, 3) != 0) ? m_image : 6'($urandom));
        sent++;
      end
      for (int i = 0; i < nseg && sent < count; i++) begin
        case ($urandom_range(0, 19))
          0: r = 16'($urandom);
          1: r = 16'($urandom_range(0, nseg));
          2: r = 16'($urandom_range(8180, 8191));
          default: r = 16'(i);
        endcase
        send_body(cur_tid, r, ($urandom_range(0, 9) == 0) ? 13'($urandom) :
                  13'($urandom_range(0, 500)), (i == nseg - 1) || ($urandom_range(0, 30) == 0));
        sent++;
      end
      if ($urandom_range(0, 5) == 0) begin
        send_header(cur_tid, 28'($urandom), 6'($urandom));
        sent++;
      end
    end
  endtask

  // several register settings between random phases
  task automatic test_config_phases();
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CFG_PAD_MODE, (ph == 3) ? 6'd0 : 6'd1);
      case (ph)
        0: write_reg(CFG_IMAGE_TYPE, 6'd2);
        1: write_reg(CFG_IMAGE_TYPE, 6'd63);
        2: write_reg(CFG_IMAGE_TYPE, 6'd0);
        default: write_reg(CFG_IMAGE_TYPE, 6'($urandom));
      endcase
      test_random_objects(300);
    end
  endtask

  initial begin
    fail_count  = 0;
    cycle_count = 0;
    rst_n       = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    in_tvalid   = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = 1'b0;
    cfg_wdata   = '0;
    cur_tid     = '0;
    m_pad       = 1'b0;
    m_image     = 6'd2;
    m_id        = '0;
    m_id_known  = 1'b0;
    clear_object();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_phases();
    drain();
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
